[rtl/fma_pkg.sv]
// ----------------------------------------------------------------------------
// fma_pkg: shared types and constants of the frame moving average
// Field widths, configuration reset value and sequencer state codes.
// ----------------------------------------------------------------------------
package fma_pkg;

	localparam int INDEX_W  = 8;
	localparam int SAMPLE_W = 8;
	localparam int CFG_W    = 5;
	localparam int CMP_W    = 13;

	localparam logic [CFG_W-1:0] WINDOW_RESET = 5'd1;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_WRITE = 7'b0000100,
		ST_READ  = 7'b0001000,
		ST_DRAIN = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

endpackage

[rtl/fma_if.sv]
// ----------------------------------------------------------------------------
// fma_if: valid/ready channels of the frame moving average
// Sample input, averaged result output and window configuration write.
// ----------------------------------------------------------------------------
interface fma_in_if import fma_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [INDEX_W-1:0]  sensor_index;
	logic [SAMPLE_W-1:0] sample_value;
	logic                last_in_frame;

	modport source (output valid, output sensor_index, output sample_value,
		output last_in_frame, input ready);
	modport sink (input valid, input sensor_index, input sample_value,
		input last_in_frame, output ready);
endinterface

interface fma_out_if import fma_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [INDEX_W-1:0]  sensor_index_out;
	logic [SAMPLE_W-1:0] average_value;
	logic                last_out;

	modport source (output valid, output sensor_index_out, output average_value,
		output last_out, input ready);
	modport sink (input valid, input sensor_index_out, input average_value,
		input last_out, output ready);
endinterface

interface fma_cfg_if import fma_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] window_size;

	modport source (output valid, output window_size, input ready);
	modport sink (input valid, input window_size, output ready);
endinterface

[rtl/frame_moving_average.sv]
// ----------------------------------------------------------------------------
// frame_moving_average: per-sensor moving average over the last frames
// Frame slots live in one memory; a sequencer writes the sample, sums the
// window slot by slot and divides by the window with a bit-serial divider.
// ----------------------------------------------------------------------------
// Per beat the sequencer writes the sample (into every window slot in the
// filling frame), sums the window slots and divides; an out-of-range index goes
// straight to the output with a zero average. A new beat is taken only once the
// last result is in the output register. The read port reads one slot per cycle,
// the divider retires one quotient bit per cycle. After reset all 2^(slot + sensor
// address bits) entries are cleared, one a cycle; no sample is taken meanwhile.
// ----------------------------------------------------------------------------
module frame_moving_average import fma_pkg::*; #(
	parameter int MAX_WINDOW   = 16,
	parameter int SENSOR_COUNT = 256
) (
	input  logic     clk,
	input  logic     arst_n,
	fma_in_if.sink   samples,
	fma_out_if.source results,
	fma_cfg_if.sink  cfg
);

	localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int SENS_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
	localparam int ADDR_W = SLOT_W + SENS_W;
	localparam int DEPTH  = 2 ** ADDR_W;
	localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = $clog2(255 * MAX_WINDOW + 1);
	localparam int DCNT_W = $clog2(SUM_W + 1);

	state_t state_q;

	logic [CFG_W-1:0]    window_q;
	logic [SLOT_W-1:0]   ptr_q;
	logic                filling_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [SLOT_W-1:0]   cnt_q;
	logic [DCNT_W-1:0]   div_cnt_q;
	logic [SUM_W-1:0]    acc_q;
	logic [SUM_W-1:0]    quo_q;
	logic [WIN_W-1:0]    rem_q;
	logic                rd_vld_q;
	logic [SAMPLE_W-1:0] rd_q;

	logic [INDEX_W-1:0]  index_q;
	logic [SENS_W-1:0]   sens_q;
	logic [SAMPLE_W-1:0] value_q;
	logic                last_q;
	logic                in_range_q;

	logic                out_valid_q;
	logic [INDEX_W-1:0]  out_index_q;
	logic [SAMPLE_W-1:0] out_avg_q;
	logic                out_last_q;

	logic [SAMPLE_W-1:0] frame_store_q [DEPTH];

	// active window, clamped to 1..MAX_WINDOW
	logic [6:0]          win7;
	logic [WIN_W-1:0]    w_eff;
	logic [6:0]          w_ext;
	logic [SLOT_W-1:0]   ptr_eff;
	logic [6:0]          ptr_inc;
	logic [SLOT_W-1:0]   ptr_next;
	logic                cnt_last;

	logic [SENS_W-1:0]   sens_ext;
	logic                in_range;

	logic                we;
	logic [ADDR_W-1:0]   waddr;
	logic [SAMPLE_W-1:0] wdata;
	logic [ADDR_W-1:0]   raddr;

	logic [SUM_W-1:0]    acc_final;
	logic [WIN_W:0]      rem_shift;
	logic                rem_ge;
	logic                out_load;

	always_comb begin
		if (window_q == '0) begin
			win7 = 7'd1;
		end else if ({2'b00, window_q} > 7'(MAX_WINDOW)) begin
			win7 = 7'(MAX_WINDOW);
		end else begin
			win7 = {2'b00, window_q};
		end
	end

	assign w_eff    = win7[WIN_W-1:0];
	assign w_ext    = win7;
	assign ptr_eff  = (7'(ptr_q) >= w_ext) ? '0 : ptr_q;
	assign ptr_inc  = 7'(ptr_eff) + 7'd1;
	assign ptr_next = (ptr_inc >= w_ext) ? '0 : ptr_inc[SLOT_W-1:0];
	assign cnt_last = (7'(cnt_q) + 7'd1) >= w_ext;

	assign sens_ext = SENS_W'(samples.sensor_index);
	assign in_range = CMP_W'(samples.sensor_index) < CMP_W'(SENSOR_COUNT);

	// single write port: clearing sweep, or the sample into its slot(s)
	always_comb begin
		we    = 1'b0;
		waddr = {cnt_q, sens_q};
		wdata = value_q;
		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			ST_WRITE: begin
				we    = 1'b1;
				waddr = filling_q ? {cnt_q, sens_q} : {ptr_eff, sens_q};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	assign raddr = {cnt_q, sens_q};

	always_ff @(posedge clk) begin
		if (we) begin
			frame_store_q[waddr] <= wdata;
		end
		rd_q <= frame_store_q[raddr];
	end

	assign acc_final = acc_q + {{(SUM_W-SAMPLE_W){1'b0}}, rd_q};
	assign rem_shift = {rem_q, quo_q[SUM_W-1]};
	assign rem_ge    = rem_shift >= {1'b0, w_eff};
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			window_q  <= WINDOW_RESET;
			ptr_q     <= '0;
			filling_q <= 1'b1;
			clr_q     <= '0;
			cnt_q     <= '0;
			div_cnt_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			rd_vld_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					cnt_q <= '0;
					if (samples.valid) begin
						state_q <= in_range ? ST_WRITE : ST_OUT;
					end
				end
				ST_WRITE: begin
					if (filling_q && !cnt_last) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						cnt_q   <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					rd_vld_q <= 1'b1;
					if (cnt_last) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					div_cnt_q <= DCNT_W'(SUM_W);
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == DCNT_W'(1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							filling_q <= 1'b0;
							ptr_q     <= ptr_next;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// window write restarts filling
			if (cfg.valid) begin
				window_q  <= cfg.window_size;
				filling_q <= 1'b1;
				ptr_q     <= '0;
			end
		end
	end

	// datapath: accumulator and restoring divider
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				index_q    <= samples.sensor_index;
				sens_q     <= sens_ext;
				value_q    <= samples.sample_value;
				last_q     <= samples.last_in_frame;
				in_range_q <= in_range;
				acc_q      <= '0;
			end
			ST_READ: begin
				if (rd_vld_q) begin
					acc_q <= acc_final;
				end
			end
			ST_DRAIN: begin
				quo_q <= acc_final;
				rem_q <= '0;
			end
			ST_DIV: begin
				if (rem_ge) begin
					rem_q <= WIN_W'(rem_shift - {1'b0, w_eff});
				end else begin
					rem_q <= rem_shift[WIN_W-1:0];
				end
				quo_q <= {quo_q[SUM_W-2:0], rem_ge};
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// output register: hold until the result beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_index_q <= index_q;
			out_avg_q   <= in_range_q ? quo_q[SAMPLE_W-1:0] : '0;
			out_last_q  <= last_q;
		end
	end

	assign samples.ready            = (state_q == ST_IDLE);
	assign cfg.ready                = 1'b1;
	assign results.valid            = out_valid_q;
	assign results.sensor_index_out = out_index_q;
	assign results.average_value    = out_avg_q;
	assign results.last_out         = out_last_q;

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the frame moving average
// Drives sample beats and window writes through the valid/ready channels,
// predicts every per-sensor window mean and compares each result beat in order.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import fma_pkg::*;

	localparam int MAX_WINDOW       = 16;
	localparam int SENSOR_COUNT     = 256;
	localparam int MISMATCH_REPORTS = 10;
	localparam int SETTLE_CYCLES    = 60;

	typedef struct packed {
		logic [INDEX_W-1:0]  sensor;
		logic [SAMPLE_W-1:0] average;
		logic                last;
	} average_beat_t;

	logic clk;
	logic arst_n;

	fma_in_if  samples_ch ();
	fma_out_if results_ch ();
	fma_cfg_if cfg_ch ();

	frame_moving_average #(
		.MAX_WINDOW   (MAX_WINDOW),
		.SENSOR_COUNT (SENSOR_COUNT)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.results (results_ch),
		.cfg     (cfg_ch)
	);

	// Predicted frame slots, slot pointer, filling flag and window register
	logic [SAMPLE_W-1:0] slot_history [MAX_WINDOW][SENSOR_COUNT];
	int                  history_ptr;
	bit                  refilling;
	logic [CFG_W-1:0]    window_reg;

	average_beat_t pending_averages [$];
	int            send_idle_pct  = 0;
	int            stall_pct      = 0;
	int            mismatch_count = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

	function automatic average_beat_t predict_average(input logic [INDEX_W-1:0] idx,
			input logic [SAMPLE_W-1:0] val, input logic last);
		int            w;
		int            total;
		average_beat_t beat;
		w = int'(window_reg);
		if (w == 0) begin
			w = 1;
		end else if (w > MAX_WINDOW) begin
			w = MAX_WINDOW;
		end
		if (history_ptr >= w)
			history_ptr = 0;
		beat.average = '0;
		if (int'(idx) < SENSOR_COUNT) begin
			// the first frame of a window copies each sample into every slot
			if (refilling) begin
				for (int s = 0; s < w; s++)
					slot_history[s][idx] = val;
			end else begin
				slot_history[history_ptr][idx] = val;
			end
			total = 0;
			for (int s = 0; s < w; s++)
				total += slot_history[s][idx];
			beat.average = SAMPLE_W'(total / w);
		end
		beat.sensor = idx;
		beat.last   = last;
		if (last) begin
			refilling = 1'b0;
			history_ptr++;
			if (history_ptr >= w)
				history_ptr = 0;
		end
		return beat;
	endfunction

	always @(posedge clk) begin
		results_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin : check_beat
		average_beat_t want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (pending_averages.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MISMATCH_REPORTS)
					$display("unexpected result beat: sensor %0d average %0d last %0b",
						results_ch.sensor_index_out, results_ch.average_value,
						results_ch.last_out);
			end else begin
				want = pending_averages.pop_front();
				if (results_ch.sensor_index_out !== want.sensor ||
						results_ch.average_value !== want.average ||
						results_ch.last_out !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= MISMATCH_REPORTS)
						$display({"mismatch: sensor/average/last expected ",
							"%0d/%0d/%0b got %0d/%0d/%0b"},
							want.sensor, want.average, want.last,
							results_ch.sensor_index_out, results_ch.average_value,
							results_ch.last_out);
				end
			end
		end
	end

	task automatic send_sample(input logic [INDEX_W-1:0] idx, input logic [SAMPLE_W-1:0] val,
			input logic last);
		average_beat_t beat;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			samples_ch.valid <= 1'b0;
			@(posedge clk);
		end
		samples_ch.valid         <= 1'b1;
		samples_ch.sensor_index  <= idx;
		samples_ch.sample_value  <= val;
		samples_ch.last_in_frame <= last;
		@(posedge clk);
		while (!samples_ch.ready)
			@(posedge clk);
		beat = predict_average(idx, val, last);
		pending_averages = {pending_averages, beat};
	endtask

	// Hold off the sender until every pending average has come back
	task automatic wait_for_drain();
		samples_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_averages.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_window(input logic [CFG_W-1:0] value);
		wait_for_drain();
		repeat (4) @(posedge clk);
		cfg_ch.valid       <= 1'b1;
		cfg_ch.window_size <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		window_reg  = value;
		refilling   = 1'b1;
		history_ptr = 0;
	endtask

	task automatic test_default_window();
		send_sample(8'd0, 8'd0, 1'b0);
		send_sample(8'd255, 8'd255, 1'b1);
		send_sample(8'd128, 8'h7f, 1'b0);
	endtask

	task automatic test_window_limits();
		write_window(5'd16);
		send_sample(8'd3, 8'd255, 1'b1);
		send_sample(8'd3, 8'd0, 1'b1);
		send_sample(8'd3, 8'd0, 1'b0);
		send_sample(8'd200, 8'd9, 1'b1);
		// values above the maximum clamp to it
		write_window(5'd31);
		send_sample(8'd5, 8'd200, 1'b1);
		send_sample(8'd5, 8'd0, 1'b1);
		// zero acts as a window of one
		write_window(5'd0);
		send_sample(8'd5, 8'd17, 1'b0);
		send_sample(8'd255, 8'd1, 1'b1);
		write_window(5'd17);
		send_sample(8'd0, 8'd255, 1'b1);
		send_sample(8'd0, 8'd128, 1'b1);
	endtask

	// Sensors absent from the filling frame keep stale slot values
	task automatic test_stale_entries();
		write_window(5'd4);
		send_sample(8'd10, 8'd100, 1'b1);
		send_sample(8'd11, 8'd50, 1'b1);
		write_window(5'd8);
		send_sample(8'd10, 8'd8, 1'b1);
		send_sample(8'd11, 8'd255, 1'b0);
		send_sample(8'd10, 8'd1, 1'b1);
	endtask

	task automatic run_frames(input int count);
		int                  sent;
		int                  frame_len;
		int                  pool_base;
		logic [INDEX_W-1:0]  idx;
		logic [SAMPLE_W-1:0] val;
		logic                lst;
		pool_base = $urandom_range(0, SENSOR_COUNT - 8);
		sent = 0;
		while (sent < count) begin
			frame_len = $urandom_range(1, 10);
			for (int j = 0; j < frame_len && sent < count; j++) begin
				// mostly a small set of sensors, so their history builds up
				if ($urandom_range(0, 9) < 7)
					idx = INDEX_W'(pool_base + int'($urandom_range(0, 7)));
				else
					idx = INDEX_W'($urandom_range(0, 255));
				case ($urandom_range(0, 7))
					0: val = '0;
					1: val = '1;
					default: val = SAMPLE_W'($urandom_range(0, 255));
				endcase
				lst = (j == frame_len - 1);
				if ($urandom_range(0, 19) == 0)
					lst = ~lst;
				send_sample(idx, val, lst);
				sent++;
				if (sent == count / 2)
					wait_for_drain();
			end
		end
	endtask

	task automatic test_random_frames();
		int plan_window [8];
		int plan_idle   [4];
		int plan_stall  [4];
		plan_window[0] = 16;
		plan_window[1] = 1;
		plan_window[2] = 31;
		plan_window[3] = 0;
		plan_window[4] = 2;
		plan_window[5] = 17;
		plan_window[6] = $urandom_range(3, 15);
		plan_window[7] = $urandom_range(0, 31);
		plan_idle[0]  = 0;
		plan_idle[1]  = 82;
		plan_idle[2]  = 0;
		plan_idle[3]  = 33;
		plan_stall[0] = 0;
		plan_stall[1] = 0;
		plan_stall[2] = 82;
		plan_stall[3] = 33;
		for (int seg = 0; seg < 8; seg++) begin
			write_window(CFG_W'(plan_window[seg]));
			send_idle_pct = plan_idle[seg / 2];
			stall_pct     = plan_stall[seg / 2];
			run_frames(112);
		end
	endtask

	initial begin
		arst_n                   <= 1'b0;
		samples_ch.valid         <= 1'b0;
		samples_ch.sensor_index  <= '0;
		samples_ch.sample_value  <= '0;
		samples_ch.last_in_frame <= 1'b0;
		cfg_ch.valid             <= 1'b0;
		cfg_ch.window_size       <= WINDOW_RESET;
		for (int s = 0; s < MAX_WINDOW; s++)
			for (int k = 0; k < SENSOR_COUNT; k++)
				slot_history[s][k] = '0;
		history_ptr = 0;
		refilling   = 1'b1;
		window_reg  = WINDOW_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_default_window();
		test_window_limits();
		test_stale_entries();
		test_random_frames();

		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
